// ----- rtl/mppc_bulk_decompressor_assert.svh -----
// Assertion macros for the MPPC decompressor checker.
// Needs a clk and rst signal in the scope of each use.
`ifndef MPPC_BULK_DECOMPRESSOR_ASSERT_SVH
`define MPPC_BULK_DECOMPRESSOR_ASSERT_SVH

// Implication checked at every rising edge outside reset
`define MPPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle
`define MPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mppc_pkg.sv -----
// Shared types, constants and helpers of the MPPC decompressor.
// No dependencies; used by the top level, the token decoder and the checker.
`timescale 1ns / 1ps

package mppc_pkg;

  localparam int HIST_DEPTH = 65536;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int WIN_BITS   = 64;
  localparam int CNT_W      = 7;
  localparam int TOKEN_BITS = 49;

  // result status codes
  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_NEED = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // request kinds on tuser
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // decoded token at the head of the bit window
  typedef struct packed {
    logic        is_lit;
    logic [7:0]  lit;
    logic        bad;
    logic [5:0]  off_bits;   // bits taken by the offset code alone
    logic [5:0]  all_bits;   // bits taken by the literal, or by offset and length codes
    logic [16:0] off;
    logic [15:0] len;
  } tok_t;

  // history index mask for the selected level
  function automatic logic [HIST_AW-1:0] hist_mask(input logic level);
    logic [HIST_AW-1:0] m;
    m = level ? HIST_AW'(HIST_DEPTH - 1) : HIST_AW'(8192 - 1);
    return m;
  endfunction

endpackage

// ----- rtl/mppc_bulk_decompressor.sv -----
// MPPC decompressor top level: request handling, bit window, history RAM.
// Depends on mppc_pkg, mppc_ram and mppc_tok_dec.
// A push or a literal/status pull answers in the cycle after acceptance;
// a copy pull answers through the RAM read register, then the result one.
// Throughput: 1 request per cycle, held while a copy read or result waits.
// Reset: clears control state; history reads as zero through a fill mark, so
// no clearing pass is needed, and a flushed packet resets that mark at once.
`timescale 1ns / 1ps

module mppc_bulk_decompressor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,     // compression_level
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // in_byte[7:0], packet_start[8], at_front[9], flushed[10], compressed[11]
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,    // action
  input  logic        s_axis_tlast,    // packet_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // out_byte[7:0], accepted[8]
  output logic [1:0]  m_axis_tuser     // status
);

  localparam int AW = mppc_pkg::HIST_AW;

  logic                        level;
  logic [63:0]                 bit_window, bit_window_next;
  logic [mppc_pkg::CNT_W-1:0]  bit_count, bit_count_next;
  logic [AW-1:0]               write_pos, write_pos_next;
  logic [AW-1:0]               copy_src, copy_src_next;
  logic [15:0]                 copy_left, copy_left_next;
  logic                        pass_mode, pass_mode_next;
  logic                        end_seen, end_seen_next;
  logic                        error_latched, error_latched_next;
  logic [AW:0]                 fill, fill_next;
  logic                        rd_pend, rd_pend_next;
  logic                        rd_ok, rd_ok_next;
  logic                        out_valid;
  logic [7:0]                  out_byte;
  logic [1:0]                  out_status;
  logic                        out_acc;

  logic        accept;
  logic [AW-1:0] mask, wp_m, src_m, raddr, waddr;
  logic        we, re;
  logic [7:0]  wdata, rdata;
  logic        res_load;
  logic [7:0]  res_byte;
  logic [1:0]  res_status;
  logic        res_acc;
  logic [63:0] win_base;
  logic [mppc_pkg::CNT_W-1:0] cnt_base;
  logic [5:0]  k;
  mppc_pkg::tok_t tok;

  assign s_axis_tready = !rd_pend && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mask          = mppc_pkg::hist_mask(level);
  assign wp_m          = write_pos & mask;
  assign src_m         = copy_src & mask;

  mppc_tok_dec u_dec (
    .bits  (bit_window[63 -: mppc_pkg::TOKEN_BITS]),
    .level (level),
    .tok   (tok)
  );

  mppc_ram #(.WIDTH(8), .DEPTH(mppc_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next-state logic for requests and the copy write-back
  always_comb begin
    bit_window_next    = bit_window;
    bit_count_next     = bit_count;
    write_pos_next     = write_pos;
    copy_src_next      = copy_src;
    copy_left_next     = copy_left;
    pass_mode_next     = pass_mode;
    end_seen_next      = end_seen;
    error_latched_next = error_latched;
    fill_next          = fill;
    rd_pend_next       = 1'b0;
    rd_ok_next         = rd_ok;
    we                 = 1'b0;
    waddr              = wp_m;
    wdata              = 8'd0;
    re                 = 1'b0;
    raddr              = src_m;
    res_load           = 1'b0;
    res_byte           = 8'd0;
    res_status         = mppc_pkg::ST_NEED;
    res_acc            = 1'b0;
    win_base           = bit_window;
    cnt_base           = bit_count;
    k                  = 6'd0;

    if (rd_pend) begin
      // copy byte arrives: return it and append it to history
      we         = 1'b1;
      wdata      = rd_ok ? rdata : 8'd0;
      write_pos_next = (wp_m + AW'(1)) & mask;
      if ({1'b0, wp_m} + (AW+1)'(1) > fill) begin
        fill_next = {1'b0, wp_m} + (AW+1)'(1);
      end
      res_load   = 1'b1;
      res_byte   = wdata;
      res_status = mppc_pkg::ST_BYTE;
    end else if (accept) begin
      res_load = 1'b1;
      if (s_axis_tuser == mppc_pkg::ACT_PUSH) begin
        // packet start clears decode state before the byte is taken
        if (s_axis_tdata[8]) begin
          if (s_axis_tdata[9] || s_axis_tdata[10]) begin
            write_pos_next = '0;
          end
          if (s_axis_tdata[10]) begin
            fill_next = '0;
          end
          pass_mode_next     = !s_axis_tdata[11];
          win_base           = 64'd0;
          cnt_base           = '0;
          copy_left_next     = 16'd0;
          end_seen_next      = 1'b0;
          error_latched_next = 1'b0;
        end
        bit_window_next = win_base;
        bit_count_next  = cnt_base;
        if (!(end_seen && !s_axis_tdata[8]) && (cnt_base <= 7'd56)) begin
          bit_window_next = win_base |
                            ({56'd0, s_axis_tdata[7:0]} << (6'(7'd56 - cnt_base)));
          bit_count_next  = cnt_base + 7'd8;
          res_acc         = 1'b1;
          if (s_axis_tlast) begin
            end_seen_next = 1'b1;
          end
        end
      end else if (pass_mode) begin
        if (bit_count >= 7'd8) begin
          res_byte        = bit_window[63:56];
          bit_window_next = bit_window << 8;
          bit_count_next  = bit_count - 7'd8;
          res_status      = mppc_pkg::ST_BYTE;
        end else begin
          res_status = end_seen ? mppc_pkg::ST_DONE : mppc_pkg::ST_NEED;
        end
      end else if (error_latched) begin
        res_status = mppc_pkg::ST_BAD;
      end else if (copy_left != 16'd0) begin
        // next byte of a running copy
        res_load       = 1'b0;
        re             = 1'b1;
        raddr          = src_m;
        rd_ok_next     = {1'b0, src_m} < fill;
        copy_src_next  = (src_m + AW'(1)) & mask;
        copy_left_next = copy_left - 16'd1;
        rd_pend_next   = 1'b1;
      end else if (end_seen && bit_count < 7'd8) begin
        res_status = mppc_pkg::ST_DONE;
      end else if (!end_seen && bit_count < 7'(mppc_pkg::TOKEN_BITS)) begin
        res_status = mppc_pkg::ST_NEED;
      end else if (tok.is_lit) begin
        // literal goes straight to history
        k          = tok.all_bits;
        we         = 1'b1;
        wdata      = tok.lit;
        write_pos_next = (wp_m + AW'(1)) & mask;
        if ({1'b0, wp_m} + (AW+1)'(1) > fill) begin
          fill_next = {1'b0, wp_m} + (AW+1)'(1);
        end
        res_byte   = tok.lit;
        res_status = mppc_pkg::ST_BYTE;
      end else if (tok.bad) begin
        k                  = tok.off_bits;
        error_latched_next = 1'b1;
        res_status         = mppc_pkg::ST_BAD;
      end else begin
        // match: start the copy with its first byte
        k              = tok.all_bits;
        res_load       = 1'b0;
        re             = 1'b1;
        raddr          = (wp_m - tok.off[AW-1:0]) & mask;
        rd_ok_next     = {1'b0, raddr} < fill;
        copy_src_next  = (raddr + AW'(1)) & mask;
        copy_left_next = tok.len - 16'd1;
        rd_pend_next   = 1'b1;
      end
      if (s_axis_tuser == mppc_pkg::ACT_PULL && !pass_mode && k != 6'd0) begin
        bit_window_next = bit_window << k;
        bit_count_next  = (bit_count > 7'(k)) ? bit_count - 7'(k) : '0;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= 1'b0;
      bit_window    <= 64'd0;
      bit_count     <= '0;
      write_pos     <= '0;
      copy_src      <= '0;
      copy_left     <= 16'd0;
      pass_mode     <= 1'b0;
      end_seen      <= 1'b0;
      error_latched <= 1'b0;
      fill          <= '0;
      rd_pend       <= 1'b0;
      rd_ok         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        level <= cfg_wr_data;
      end
      bit_window    <= bit_window_next;
      bit_count     <= bit_count_next;
      write_pos     <= write_pos_next;
      copy_src      <= copy_src_next;
      copy_left     <= copy_left_next;
      pass_mode     <= pass_mode_next;
      end_seen      <= end_seen_next;
      error_latched <= error_latched_next;
      fill          <= fill_next;
      rd_pend       <= rd_pend_next;
      rd_ok         <= rd_ok_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_byte   <= res_byte;
      out_status <= res_status;
      out_acc    <= res_acc;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_acc, out_byte};
  assign m_axis_tuser  = out_status;

endmodule

// ----- rtl/mppc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mppc_tok_dec.sv -----
// Token decoder: literal, copy offset and copy length at the window head.
// Depends on mppc_pkg.
`timescale 1ns / 1ps

module mppc_tok_dec (
  input  logic [mppc_pkg::TOKEN_BITS-1:0] bits,   // window head, MSB first
  input  logic                            level,
  output mppc_pkg::tok_t                  tok
);

  logic [31:0] acc;
  logic [31:0] acc2;
  logic [mppc_pkg::TOKEN_BITS-1:0] rest;
  logic [4:0]  ones;
  logic        run;
  logic [4:0]  maxn;
  logic [5:0]  k1;
  logic [16:0] off;
  logic [31:0] lbits;
  logic [4:0]  ex;
  logic [16:0] lmask;

  assign acc = bits[mppc_pkg::TOKEN_BITS-1 -: 32];

  // offset code
  always_comb begin
    if (level) begin
      maxn = 5'd14;
      if (acc[31:27] == 5'b11111) begin
        off = 17'(acc[26:21]);             k1 = 6'd11;
      end else if (acc[31:27] == 5'b11110) begin
        off = 17'(acc[26:19]) + 17'd64;    k1 = 6'd13;
      end else if (acc[31:28] == 4'b1110) begin
        off = 17'(acc[27:17]) + 17'd320;   k1 = 6'd15;
      end else begin
        off = 17'(acc[28:13]) + 17'd2368;  k1 = 6'd19;
      end
    end else begin
      maxn = 5'd11;
      if (acc[31:28] == 4'b1111) begin
        off = 17'(acc[27:22]);             k1 = 6'd10;
      end else if (acc[31:28] == 4'b1110) begin
        off = 17'(acc[27:20]) + 17'd64;    k1 = 6'd12;
      end else begin
        off = 17'(acc[28:16]) + 17'd320;   k1 = 6'd16;
      end
    end
  end

  // length code: leading ones, a zero, then (if any ones) that many plus one value bits
  assign rest = bits << k1;
  assign acc2 = rest[mppc_pkg::TOKEN_BITS-1 -: 32];

  always_comb begin
    ones = 5'd0;
    run  = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (run && acc2[31-i]) begin
        ones = ones + 5'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  assign ex    = ones + 5'd1;
  assign lbits = acc2 >> (5'd30 - {ones[3:0], 1'b0});
  assign lmask = (17'd1 << ex) - 17'd1;

  always_comb begin
    tok.is_lit   = !acc[31] || (acc[31:30] == 2'b10);
    tok.lit      = acc[31] ? {1'b1, acc[29:23]} : {1'b0, acc[30:24]};
    tok.off      = off;
    tok.off_bits = k1;
    tok.bad      = (ones > maxn);
    if (!acc[31]) begin
      tok.all_bits = 6'd8;
    end else if (!acc[30]) begin
      tok.all_bits = 6'd9;
    end else if (ones == 5'd0) begin
      tok.all_bits = k1 + 6'd1;
    end else begin
      tok.all_bits = k1 + {ones, 1'b0} + 6'd2;
    end
    if (ones == 5'd0) begin
      tok.len = 16'd3;
    end else begin
      tok.len = 16'((17'd1 << ex) + (lbits[16:0] & lmask));
    end
  end

endmodule

// ----- rtl/mppc_chk.sv -----
// Port-level checker for the MPPC decompressor, bound to the top level.
// Depends on mppc_pkg and mppc_bulk_decompressor_assert.svh.
`timescale 1ns / 1ps
`include "mppc_bulk_decompressor_assert.svh"

module mppc_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a push request answers in the next cycle with a needs-input result
  `MPPC_ASSERT_NEXT(a_push_next, s_axis_tvalid && s_axis_tready && s_axis_tuser == mppc_pkg::ACT_PUSH, m_axis_tvalid && m_axis_tuser == mppc_pkg::ST_NEED, "push result missing")

  // the accepted flag appears only on push results
  `MPPC_ASSERT_IMP(a_acc_push, m_axis_tvalid && m_axis_tuser != mppc_pkg::ST_NEED, m_axis_tdata[8] == 1'b0, "accepted flag on non-push result")

  // data byte is zero unless a byte is given
  `MPPC_ASSERT_IMP(a_byte_zero, m_axis_tvalid && m_axis_tuser != mppc_pkg::ST_BYTE, m_axis_tdata[7:0] == 8'd0, "stray data byte")

  // a stalled result holds
  `MPPC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind mppc_bulk_decompressor mppc_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
